@@ hdl/cnfsa_pkg.sv @@
`timescale 1ns / 1ps

package cnfsa_pkg;

	// default number of slots held by the block
	localparam int SLOTS_DEF = 1024;

	// flag memory row: one row holds the taken flags of this many slots
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	// field and register widths
	localparam int COUNT_W = 11;
	localparam int FIELD_W = 10;

	// slot_count after reset
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// operation codes
	localparam logic OP_CLAIM   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic               operation;
		logic [FIELD_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] granted_slot;
		logic               full_res;
	} rsp_t;

endpackage

@@ hdl/circular_next_free_slot_allocator_core.sv @@
`timescale 1ns / 1ps

// Circular next-free-slot allocator. Taken flags live in a memory of 64-bit rows
// (ceil(SLOTS/64) rows). A claim scans the rows from the row of its preferred
// slot, one row read per cycle, wrapping at the last usable row and ending with
// the low part of the starting row; a shared masked priority encoder picks the
// first free flag. A claim visits at most ceil(min(slot_count,SLOTS)/64)+1
// rows; the row scan sets how long a claim holds the input, and the next
// transaction is taken only after the claim's result has moved to the output
// register. While the output register still holds an untaken result, a finished
// claim waits in its done state until that result is taken.
// A release is a read-modify-write of one row. The block takes one transaction
// at a time. After reset a clearing pass writes every row to zero, during which
// no transaction is taken. With SLOTS above 1024 the granted index carries its
// low 10 bits only.
module circular_next_free_slot_allocator_core #(
	parameter int SLOTS = cnfsa_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cnfsa_pkg::req_t               req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cnfsa_pkg::rsp_t               rsp,
	input  logic                          cfg_we,
	input  logic [cnfsa_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int WB    = cnfsa_pkg::WORD_BITS;
	localparam int BW    = cnfsa_pkg::BIT_W;
	localparam int WORDS = (SLOTS + WB - 1) / WB;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IX_W  = WA_W + BW;
	localparam int CMP_W = (IX_W + 1 > cnfsa_pkg::COUNT_W) ? IX_W + 1 : cnfsa_pkg::COUNT_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_REL   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	typedef logic [WA_W-1:0] waddr_t;

	function automatic logic [BW-1:0] first_set(input cnfsa_pkg::word_t m);
		logic [BW-1:0] b;
		b = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (m[i]) begin
				b = BW'(i);
			end
		end
		return b;
	endfunction

	logic [2:0]                    state_q;
	logic [cnfsa_pkg::COUNT_W-1:0] count_q;
	waddr_t                        clr_w_q;

	// search context
	waddr_t          st_w_q;
	logic [BW-1:0]   st_b_q;
	waddr_t          iss_w_q;
	logic            iss_fin_q;
	logic            iss_done_q;

	// evaluate stage, aligned with the memory read data
	logic            ev_vld_s1;
	waddr_t          ev_w_s1;
	logic            ev_first_s1;
	logic            ev_fin_s1;

	// pending result
	logic [IX_W-1:0] res_ix_q;
	logic            res_full_q;

	logic            rsp_valid_q;
	cnfsa_pkg::rsp_t rsp_q;

	// flag memory
	cnfsa_pkg::word_t mem_q [WORDS];
	cnfsa_pkg::word_t rd_q;
	logic             mem_we;
	waddr_t           mem_wa;
	waddr_t           mem_ra;
	cnfsa_pkg::word_t mem_wd;

	// usable count and request decode
	logic [CMP_W-1:0] cnt_eff;
	logic [CMP_W-1:0] cnt_m1;
	logic [CMP_W-1:0] slot_ext;
	logic             slot_in_rng;
	logic [IX_W-1:0]  start_ix;
	waddr_t           start_w;
	logic [BW-1:0]    start_b;
	waddr_t           last_w;
	logic [BW-1:0]    last_b;
	logic             accept;

	always_comb begin
		logic [CMP_W-1:0] cfg_ext;
		logic [CMP_W-1:0] slots_c;
		cfg_ext     = CMP_W'(count_q);
		slots_c     = CMP_W'(SLOTS);
		cnt_eff     = (cfg_ext < slots_c) ? cfg_ext : slots_c;
		cnt_m1      = cnt_eff - CMP_W'(1);
		slot_ext    = CMP_W'(req.slot);
		slot_in_rng = slot_ext < cnt_eff;
		start_ix    = slot_in_rng ? slot_ext[IX_W-1:0] : '0;
		start_w     = start_ix[IX_W-1:BW];
		start_b     = start_ix[BW-1:0];
		last_w      = cnt_m1[IX_W-1:BW];
		last_b      = cnt_m1[BW-1:0];
	end

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// candidate flags of the row under evaluation
	cnfsa_pkg::word_t range_m;
	cnfsa_pkg::word_t ge_m;
	cnfsa_pkg::word_t pos_m;
	cnfsa_pkg::word_t cand;
	logic             hit;
	logic [BW-1:0]    hit_b;
	logic             give_up;

	always_comb begin
		range_m = (ev_w_s1 == last_w) ? ('1 >> (~last_b)) : '1;
		ge_m    = '1 << st_b_q;
		pos_m   = ev_first_s1 ? ge_m : (ev_fin_s1 ? ~ge_m : '1);
		cand    = ~rd_q & range_m & pos_m;
		hit     = (state_q == ST_SCAN) && ev_vld_s1 && (|cand);
		hit_b   = first_set(cand);
		give_up = (state_q == ST_SCAN) && ev_vld_s1 && !(|cand) && ev_fin_s1;
	end

	// next row in circular order over the usable rows
	function automatic waddr_t next_w(input waddr_t w, input waddr_t lw);
		return (w == lw) ? '0 : w + WA_W'(1);
	endfunction

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_w_q;
			end
			ST_IDLE: begin
				mem_ra = start_w;
			end
			ST_SCAN: begin
				mem_ra = iss_w_q;
				mem_we = hit;
				mem_wa = ev_w_s1;
				mem_wd = rd_q | (cnfsa_pkg::word_t'(1) << hit_b);
			end
			ST_REL: begin
				mem_we = 1'b1;
				mem_wa = st_w_q;
				mem_wd = rd_q & ~(cnfsa_pkg::word_t'(1) << st_b_q);
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= cnfsa_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		waddr_t nw;
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_w_q     <= '0;
			st_w_q      <= '0;
			st_b_q      <= '0;
			iss_w_q     <= '0;
			iss_fin_q   <= 1'b0;
			iss_done_q  <= 1'b0;
			ev_vld_s1   <= 1'b0;
			ev_w_s1     <= '0;
			ev_first_s1 <= 1'b0;
			ev_fin_s1   <= 1'b0;
			res_ix_q    <= '0;
			res_full_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_w_q <= clr_w_q + WA_W'(1);
					if (clr_w_q == WA_W'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						st_w_q <= start_w;
						st_b_q <= start_b;
						if (req.operation == cnfsa_pkg::OP_RELEASE) begin
							if (slot_in_rng) begin
								state_q <= ST_REL;
							end
						end else if (cnt_eff == '0) begin
							res_ix_q   <= '0;
							res_full_q <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							// first visit of the start row is read now
							nw          = next_w(start_w, last_w);
							ev_vld_s1   <= 1'b1;
							ev_w_s1     <= start_w;
							ev_first_s1 <= 1'b1;
							ev_fin_s1   <= 1'b0;
							iss_w_q     <= nw;
							iss_fin_q   <= (nw == start_w);
							iss_done_q  <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit || give_up) begin
						ev_vld_s1  <= 1'b0;
						res_ix_q   <= hit ? {ev_w_s1, hit_b} : '0;
						res_full_q <= !hit;
						state_q    <= ST_DONE;
					end else begin
						// advance the row read one ahead of evaluation
						nw          = next_w(iss_w_q, last_w);
						ev_vld_s1   <= !iss_done_q;
						ev_w_s1     <= iss_w_q;
						ev_first_s1 <= 1'b0;
						ev_fin_s1   <= iss_fin_q;
						if (!iss_done_q) begin
							if (iss_fin_q) begin
								iss_done_q <= 1'b1;
							end else begin
								iss_w_q   <= nw;
								iss_fin_q <= (nw == st_w_q);
							end
						end
					end
				end
				ST_REL: begin
					state_q <= ST_IDLE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q        <= 1'b1;
			rsp_q.granted_slot <= cnfsa_pkg::FIELD_W'(res_ix_q);
			rsp_q.full_res     <= res_full_q;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a full answer never carries a slot index
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.full_res |-> rsp_q.granted_slot == '0)
		else $error("full result with nonzero slot");

	// the evaluate stage is only live during a scan
	a_ev_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ev_vld_s1 |-> state_q == ST_SCAN)
		else $error("evaluate stage live outside scan");

	// the flag memory is never written while a transaction may be taken
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q != ST_IDLE)
		else $error("flag write while idle");

	// a new result only follows the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside done state");

endmodule
